@@ design/device_presence_table_assert.svh @@
// ----------------------------------------------------------------------------
// Device presence table assertion macros
// Shared concurrent assertion forms for the checker; clocked on clk,
// disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEVICE_PRESENCE_TABLE_ASSERT_SVH
`define DEVICE_PRESENCE_TABLE_ASSERT_SVH

// Same-cycle implication.
`define DPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/dpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Device presence table package
// Sizes, codes and shared types of the presence table.
// ----------------------------------------------------------------------------
package dpt_pkg;

    localparam int MAX_ENTRIES  = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int RES_W = $clog2(RESULT_LIMIT + 1);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int REQ_W       = 2;
    localparam int ADDR_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int TIME_W      = 32;
    localparam int STATUS_W    = 3;
    localparam int DEVCNT_W    = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd10;
    localparam logic [BYTE_W-1:0] PERIOD_RESET  = 8'd8;

    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD  = 1'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_ANNOUNCE = 2'd0,
        REQ_TICK     = 2'd1,
        REQ_GROUP    = 2'd2,
        REQ_NONE     = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_UPDATED   = 3'd0,
        ST_ADDED     = 3'd1,
        ST_FULL      = 3'd2,
        ST_TICK_KEEP = 3'd3,
        ST_TICK_DROP = 3'd4,
        ST_SEND      = 3'd5,
        ST_NO_MATCH  = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_SHIFT,
        B_DONE
    } back_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] timeout_seconds;
        logic [BYTE_W-1:0] cleanup_period;
    } cfg_t;

    // One queued request with the time stamp and cleanup decision attached.
    typedef struct packed {
        req_kind_t         kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] grp;
        logic [BYTE_W-1:0] pos;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] par;
        logic [TIME_W-1:0] now;
        logic              cleanup;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] grp;
        logic [BYTE_W-1:0] pos;
        logic [TIME_W-1:0] seen;
    } entry_t;

endpackage

@@ design/dpt_ifs.sv @@
// ----------------------------------------------------------------------------
// Device presence table channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dpt_req_if import dpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ADDR_W-1:0] peer_address;
    logic [BYTE_W-1:0] group_id;
    logic [BYTE_W-1:0] position;
    logic [BYTE_W-1:0] command_code;
    logic [BYTE_W-1:0] command_param;

    modport source (
        output valid, req_type, peer_address, group_id, position,
               command_code, command_param,
        input  ready
    );
    modport sink (
        input  valid, req_type, peer_address, group_id, position,
               command_code, command_param,
        output ready
    );
endinterface

interface dpt_rsp_if import dpt_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   target_address;
    logic [BYTE_W-1:0]   out_command;
    logic [BYTE_W-1:0]   out_param;
    logic [DEVCNT_W-1:0] device_count;
    logic                last;

    modport source (
        output valid, status, target_address, out_command, out_param,
               device_count, last,
        input  ready
    );
    modport sink (
        input  valid, status, target_address, out_command, out_param,
               device_count, last,
        output ready
    );
endinterface

@@ design/dpt_front.sv @@
// ----------------------------------------------------------------------------
// Device presence table front end
// Accepts request beats, keeps the seconds and cleanup counters and tags
// each request with its time stamp and cleanup decision.
// ----------------------------------------------------------------------------
module dpt_front import dpt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dpt_req_if.sink       req,
    input  cfg_t          cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output item_t         push_item
);

    logic [TIME_W-1:0] seconds_reg;
    logic [TIME_W-1:0] seconds_next;
    logic [BYTE_W-1:0] ticks_reg;
    logic [BYTE_W-1:0] ticks_next;
    logic [TIME_W-1:0] seconds_plus;
    logic [BYTE_W-1:0] ticks_plus;
    req_kind_t         kind;
    logic              is_tick;
    logic              run_cleanup;
    logic              accept;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign accept     = req.valid && push_ready;

    always_comb
    begin
        kind         = req_kind_t'(req.req_type);
        is_tick      = (kind == REQ_TICK);
        seconds_plus = seconds_reg + TIME_W'(1);
        ticks_plus   = ticks_reg + BYTE_W'(1);
        // The counters advance before the cleanup test is made.
        run_cleanup  = is_tick && (ticks_plus > cfg.cleanup_period);

        push_item.kind    = kind;
        push_item.addr    = req.peer_address;
        push_item.grp     = req.group_id;
        push_item.pos     = req.position;
        push_item.cmd     = req.command_code;
        push_item.par     = req.command_param;
        push_item.now     = is_tick ? seconds_plus : seconds_reg;
        push_item.cleanup = run_cleanup;

        seconds_next = seconds_reg;
        ticks_next   = ticks_reg;
        if (accept && is_tick)
        begin
            seconds_next = seconds_plus;
            ticks_next   = run_cleanup ? '0 : ticks_plus;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_reg <= '0;
            ticks_reg   <= '0;
        end
        else
        begin
            seconds_reg <= seconds_next;
            ticks_reg   <= ticks_next;
        end
    end

endmodule

@@ design/dpt_fifo.sv @@
// ----------------------------------------------------------------------------
// Device presence table request queue
// Short queue of tagged requests between the front end and the table engine.
// ----------------------------------------------------------------------------
module dpt_fifo import dpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    item_t                 slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] fill_reg;
    logic [FIFO_CNT_W-1:0] fill_next;
    logic                  push;
    logic                  pop;

    assign in_ready  = (fill_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign out_valid = (fill_reg != '0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? FIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? FIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/dpt_back.sv @@
// ----------------------------------------------------------------------------
// Device presence table engine
// Walks the entry memory one entry a cycle, held by result stalls in a group
// scan, to update, append, expire or fan out; drives the registered results.
// ----------------------------------------------------------------------------
module dpt_back import dpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    input  cfg_t    cfg,
    dpt_rsp_if.source rsp
);

    back_state_t         state_reg, state_next;
    item_t               cur_reg, cur_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [RES_W-1:0]    sent_reg, sent_next;
    logic                pend_valid_reg, pend_valid_next;
    status_t             pend_status_reg, pend_status_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [BYTE_W-1:0]   pend_cmd_reg, pend_cmd_next;
    logic [BYTE_W-1:0]   pend_par_reg, pend_par_next;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ADDR_W-1:0]   out_addr_reg, out_addr_next;
    logic [BYTE_W-1:0]   out_cmd_reg, out_cmd_next;
    logic [BYTE_W-1:0]   out_par_reg, out_par_next;
    logic [DEVCNT_W-1:0] out_count_reg, out_count_next;
    logic                out_last_reg, out_last_next;

    entry_t              entry_mem_reg [MAX_ENTRIES];
    entry_t              rd_entry_reg;
    logic [IDX_W-1:0]    rd_idx;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_idx;
    entry_t              wr_entry;

    logic                can_emit;
    logic                at_end;
    logic [TIME_W-1:0]   expire_at;
    entry_t              new_entry;

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.target_address = out_addr_reg;
    assign rsp.out_command    = out_cmd_reg;
    assign rsp.out_param      = out_par_reg;
    assign rsp.device_count   = out_count_reg;
    assign rsp.last           = out_last_reg;

    assign can_emit = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        idx_next         = idx_reg;
        count_next       = count_reg;
        sent_next        = sent_reg;
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_addr_next   = pend_addr_reg;
        pend_cmd_next    = pend_cmd_reg;
        pend_par_next    = pend_par_reg;

        out_valid_next   = out_valid_reg && !rsp.ready;
        out_status_next  = out_status_reg;
        out_addr_next    = out_addr_reg;
        out_cmd_next     = out_cmd_reg;
        out_par_next     = out_par_reg;
        out_count_next   = out_count_reg;
        out_last_next    = out_last_reg;

        item_ready = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = idx_reg[IDX_W-1:0];
        wr_entry   = rd_entry_reg;

        at_end    = (idx_reg == count_reg);
        expire_at = rd_entry_reg.seen + TIME_W'(cfg.timeout_seconds);
        new_entry.addr = cur_reg.addr;
        new_entry.grp  = cur_reg.grp;
        new_entry.pos  = cur_reg.pos;
        new_entry.seen = cur_reg.now;

        case (state_reg)
            B_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cur_next         = item;
                    idx_next         = '0;
                    sent_next        = '0;
                    pend_valid_next  = 1'b0;
                    pend_addr_next   = '0;
                    pend_cmd_next    = '0;
                    pend_par_next    = '0;
                    pend_status_next = ST_NO_MATCH;
                    case (item.kind)
                        REQ_ANNOUNCE, REQ_GROUP:
                        begin
                            state_next = B_SCAN;
                        end
                        REQ_TICK:
                        begin
                            if (item.cleanup)
                            begin
                                state_next = B_SCAN;
                            end
                            else
                            begin
                                pend_status_next = ST_TICK_KEEP;
                                state_next       = B_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = B_DONE;
                        end
                    endcase
                end
            end

            B_SCAN:
            begin
                case (cur_reg.kind)
                    REQ_ANNOUNCE:
                    begin
                        if (at_end)
                        begin
                            if (count_reg < CNT_W'(MAX_ENTRIES))
                            begin
                                wr_en            = 1'b1;
                                wr_idx           = count_reg[IDX_W-1:0];
                                wr_entry         = new_entry;
                                count_next       = count_reg + CNT_W'(1);
                                pend_status_next = ST_ADDED;
                            end
                            else
                            begin
                                pend_status_next = ST_FULL;
                            end
                            state_next = B_DONE;
                        end
                        else if (rd_entry_reg.addr == cur_reg.addr)
                        begin
                            wr_en            = 1'b1;
                            wr_entry         = new_entry;
                            pend_status_next = ST_UPDATED;
                            state_next       = B_DONE;
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end

                    REQ_TICK:
                    begin
                        if (at_end)
                        begin
                            pend_status_next = ST_TICK_KEEP;
                            state_next       = B_DONE;
                        end
                        else if (expire_at < cur_reg.now)
                        begin
                            // Later entries move down one place from here on.
                            idx_next   = idx_reg + CNT_W'(1);
                            state_next = B_SHIFT;
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end

                    REQ_GROUP:
                    begin
                        if (at_end || (sent_reg == RES_W'(RESULT_LIMIT)))
                        begin
                            if (!pend_valid_reg)
                            begin
                                pend_status_next = ST_NO_MATCH;
                            end
                            state_next = B_DONE;
                        end
                        else if (rd_entry_reg.grp == cur_reg.grp)
                        begin
                            // A match is held back one step so that the final
                            // beat can carry the last flag.
                            if (!pend_valid_reg || can_emit)
                            begin
                                if (pend_valid_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_status_next = pend_status_reg;
                                    out_addr_next   = pend_addr_reg;
                                    out_cmd_next    = pend_cmd_reg;
                                    out_par_next    = pend_par_reg;
                                    out_count_next  = DEVCNT_W'(count_reg);
                                    out_last_next   = 1'b0;
                                end
                                pend_valid_next  = 1'b1;
                                pend_status_next = ST_SEND;
                                pend_addr_next   = rd_entry_reg.addr;
                                pend_cmd_next    = cur_reg.cmd;
                                pend_par_next    = cur_reg.par;
                                sent_next        = sent_reg + RES_W'(1);
                                idx_next         = idx_reg + CNT_W'(1);
                            end
                        end
                        else
                        begin
                            idx_next = idx_reg + CNT_W'(1);
                        end
                    end

                    default:
                    begin
                        pend_status_next = ST_NO_MATCH;
                        state_next       = B_DONE;
                    end
                endcase
            end

            B_SHIFT:
            begin
                if (idx_reg < count_reg)
                begin
                    wr_en    = 1'b1;
                    wr_idx   = IDX_W'(idx_reg - CNT_W'(1));
                    wr_entry = rd_entry_reg;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    count_next       = count_reg - CNT_W'(1);
                    pend_status_next = ST_TICK_DROP;
                    state_next       = B_DONE;
                end
            end

            B_DONE:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_status_reg;
                    out_addr_next   = pend_addr_reg;
                    out_cmd_next    = pend_cmd_reg;
                    out_par_next    = pend_par_reg;
                    out_count_next  = DEVCNT_W'(count_reg);
                    out_last_next   = 1'b1;
                    state_next      = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        // The read runs one index ahead, so the data for idx_reg is ready
        // in the cycle that examines it.
        rd_idx = idx_next[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        idx_reg         <= idx_next;
        sent_reg        <= sent_next;
        pend_status_reg <= pend_status_next;
        pend_addr_reg   <= pend_addr_next;
        pend_cmd_reg    <= pend_cmd_next;
        pend_par_reg    <= pend_par_next;
        out_status_reg  <= out_status_next;
        out_addr_reg    <= out_addr_next;
        out_cmd_reg     <= out_cmd_next;
        out_par_reg     <= out_par_next;
        out_count_reg   <= out_count_next;
        out_last_reg    <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem_reg[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= entry_mem_reg[rd_idx];
    end

endmodule

@@ design/device_presence_table.sv @@
// ----------------------------------------------------------------------------
// Device presence table
// Ordered list of peer devices with announce, expiry and group fan-out.
//
//   Channel  Direction  Beat
//   req      in         one request: announce, tick or group command
//   rsp      out        one result; a group command gives one per member
//   cfg      in         register write, no handshake, index 0 or 1
//
// While it scans the list, the engine reads the entry memory one entry per
// cycle, except while a group match waits on a stalled result channel. A
// tick without cleanup and an unused request type skip the scan. A stall on
// the result channel holds the engine until its beat is taken.
// A two-deep queue lets the front end take requests while a scan runs.
// After reset the list is empty; the entry memory needs no clearing pass.
// ----------------------------------------------------------------------------
module device_presence_table import dpt_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    dpt_req_if.sink                req,
    dpt_rsp_if.source              rsp,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg;
    cfg_t  cfg_next;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TIMEOUT: cfg_next.timeout_seconds = cfg_data;
                CFG_PERIOD:  cfg_next.cleanup_period  = cfg_data;
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_seconds <= TIMEOUT_RESET;
            cfg_reg.cleanup_period  <= PERIOD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cfg        (cfg_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dpt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_item   (push_item),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_item  (pop_item)
    );

    dpt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .cfg        (cfg_reg),
        .rsp        (rsp)
    );

endmodule

@@ design/dpt_checker.sv @@
// ----------------------------------------------------------------------------
// Device presence table checker
// Watches the result channel of the presence table over time.
// ----------------------------------------------------------------------------
`include "device_presence_table_assert.svh"

module dpt_checker import dpt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [ADDR_W-1:0]   target_address,
    input logic [BYTE_W-1:0]   out_command,
    input logic [BYTE_W-1:0]   out_param,
    input logic [DEVCNT_W-1:0] device_count,
    input logic                last
);

    `DPT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(target_address) && $stable(last), "result beat changed while stalled")

    `DPT_ASSERT_NOW(a_status_code, rsp_valid, status <= ST_NO_MATCH, "undefined status code")

    `DPT_ASSERT_NOW(a_single_beat, rsp_valid && (status != ST_SEND), last && (target_address == '0) && (out_command == '0) && (out_param == '0), "non-send result not a clean final beat")

    `DPT_ASSERT_NEXT(a_group_count, rsp_valid && rsp_ready && (status == ST_SEND) && !last, !rsp_valid || (device_count == $past(device_count)), "list size changed within a group command")

endmodule

bind device_presence_table dpt_checker u_dpt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .target_address (rsp.target_address),
    .out_command    (rsp.out_command),
    .out_param      (rsp.out_param),
    .device_count   (rsp.device_count),
    .last           (rsp.last)
);

@@ tb/device_presence_table_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Device presence table testbench
// Drives announce, tick and group command requests through the request
// channel, predicts every result beat with a behavioral copy of the table
// and checks the result channel in order. Runs a directed opening, then
// random phases under several register settings and idling patterns on
// both channels.
// ----------------------------------------------------------------------------
module device_presence_table_test;
    import dpt_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 8;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 37;
    localparam int POOL_SIZE     = 20;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   target;
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   param;
        logic [DEVCNT_W-1:0] count;
        logic                last;
    } rsp_beat_t;

    // Behavioral copy of the table and the queue of result beats it predicts.
    class presence_scoreboard;
        logic [ADDR_W-1:0] dev_addr  [MAX_ENTRIES];
        logic [BYTE_W-1:0] dev_group [MAX_ENTRIES];
        logic [BYTE_W-1:0] dev_pos   [MAX_ENTRIES];
        logic [TIME_W-1:0] dev_seen  [MAX_ENTRIES];
        int                dev_count;
        logic [TIME_W-1:0] now_sec;
        logic [BYTE_W-1:0] tick_count;
        logic [BYTE_W-1:0] timeout_cfg;
        logic [BYTE_W-1:0] period_cfg;
        rsp_beat_t         expected_beats[$];
        int                errors;

        function new();
            dev_count   = 0;
            now_sec     = '0;
            tick_count  = '0;
            timeout_cfg = TIMEOUT_RESET;
            period_cfg  = PERIOD_RESET;
            errors      = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_TIMEOUT: timeout_cfg = value;
                CFG_PERIOD:  period_cfg  = value;
                default: ;
            endcase
        endfunction

        function void push_beat(status_t st, logic [ADDR_W-1:0] target,
                                logic [BYTE_W-1:0] command, logic [BYTE_W-1:0] param,
                                logic last);
            rsp_beat_t beat;
            beat.status  = st;
            beat.target  = target;
            beat.command = command;
            beat.param   = param;
            beat.count   = DEVCNT_W'(dev_count);
            beat.last    = last;
            expected_beats.insert(expected_beats.size(), beat);
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                   logic [BYTE_W-1:0] grp, logic [BYTE_W-1:0] pos,
                                   logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] par);
            int      i;
            int      j;
            int      hit;
            int      total;
            int      sent;
            status_t st;
            logic [TIME_W-1:0] limit_sec;
            hit = -1;
            case (kind)
                REQ_ANNOUNCE:
                begin
                    for (i = 0; i < dev_count; i++)
                        if (hit < 0 && dev_addr[i] == addr)
                            hit = i;
                    if (hit >= 0)
                    begin
                        dev_group[hit] = grp;
                        dev_pos[hit]   = pos;
                        dev_seen[hit]  = now_sec;
                        push_beat(ST_UPDATED, '0, '0, '0, 1'b1);
                    end
                    else if (dev_count < MAX_ENTRIES)
                    begin
                        dev_addr[dev_count]  = addr;
                        dev_group[dev_count] = grp;
                        dev_pos[dev_count]   = pos;
                        dev_seen[dev_count]  = now_sec;
                        dev_count++;
                        push_beat(ST_ADDED, '0, '0, '0, 1'b1);
                    end
                    else
                        push_beat(ST_FULL, '0, '0, '0, 1'b1);
                end
                REQ_TICK:
                begin
                    st         = ST_TICK_KEEP;
                    now_sec    = now_sec + 1'b1;
                    tick_count = tick_count + 1'b1;
                    if (tick_count > period_cfg)
                    begin
                        // Only the first expired entry goes; the sum wraps at 32 bits.
                        for (i = 0; i < dev_count; i++)
                        begin
                            limit_sec = dev_seen[i] + TIME_W'(timeout_cfg);
                            if (hit < 0 && limit_sec < now_sec)
                                hit = i;
                        end
                        if (hit >= 0)
                        begin
                            for (j = hit; j + 1 < dev_count; j++)
                            begin
                                dev_addr[j]  = dev_addr[j + 1];
                                dev_group[j] = dev_group[j + 1];
                                dev_pos[j]   = dev_pos[j + 1];
                                dev_seen[j]  = dev_seen[j + 1];
                            end
                            dev_count--;
                            st = ST_TICK_DROP;
                        end
                        tick_count = '0;
                    end
                    push_beat(st, '0, '0, '0, 1'b1);
                end
                REQ_GROUP:
                begin
                    total = 0;
                    for (i = 0; i < dev_count; i++)
                        if (dev_group[i] == grp && total < RESULT_LIMIT)
                            total++;
                    sent = 0;
                    for (i = 0; i < dev_count; i++)
                        if (dev_group[i] == grp && sent < total)
                        begin
                            push_beat(ST_SEND, dev_addr[i], cmd, par, sent == total - 1);
                            sent++;
                        end
                    if (total == 0)
                        push_beat(ST_NO_MATCH, '0, '0, '0, 1'b1);
                end
                default:
                    push_beat(ST_NO_MATCH, '0, '0, '0, 1'b1);
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val)
            begin
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [STATUS_W-1:0] st, logic [ADDR_W-1:0] target,
                                   logic [BYTE_W-1:0] command, logic [BYTE_W-1:0] param,
                                   logic [DEVCNT_W-1:0] count, logic last);
            rsp_beat_t exp_beat;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat: expected none, actual status %0d target %h",
                         $time, st, target);
                errors++;
                return;
            end
            exp_beat = expected_beats.pop_front();
            compare_field("status", 32'(exp_beat.status), 32'(st));
            compare_field("target_address", exp_beat.target, target);
            compare_field("out_command", 32'(exp_beat.command), 32'(command));
            compare_field("out_param", 32'(exp_beat.param), 32'(param));
            compare_field("device_count", 32'(exp_beat.count), 32'(count));
            compare_field("last", 32'(exp_beat.last), 32'(last));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    dpt_req_if req_ch ();
    dpt_rsp_if rsp_ch ();

    presence_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int cycle_count = 0;

    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    int phase_timeout [PHASE_COUNT] = '{0, 3, 255, 6, 10};
    int phase_period  [PHASE_COUNT] = '{0, 1, 2, 0, 4};
    int phase_send    [PHASE_COUNT] = '{0, 81, 0, 19, 0};
    int phase_recv    [PHASE_COUNT] = '{0, 0, 81, 19, 0};

    device_presence_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: ready changes at the falling edge, beats are taken at the rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_result(rsp_ch.status, rsp_ch.target_address, rsp_ch.out_command,
                                rsp_ch.out_param, rsp_ch.device_count, rsp_ch.last);
        end
    end

    // Entered and left just after a falling edge; valid stays high on return.
    task automatic send_item(logic [REQ_W-1:0] kind, logic [ADDR_W-1:0] addr,
                             logic [BYTE_W-1:0] grp, logic [BYTE_W-1:0] pos,
                             logic [BYTE_W-1:0] cmd, logic [BYTE_W-1:0] par);
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_ch.req_type      = kind;
        req_ch.peer_address  = addr;
        req_ch.group_id      = grp;
        req_ch.position      = pos;
        req_ch.command_code  = cmd;
        req_ch.command_param = par;
        req_ch.valid         = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        sb.note_request(kind, addr, grp, pos, cmd, par);
        @(negedge clk);
    endtask

    task automatic wait_for_results();
        req_ch.valid = 1'b0;
        while (sb.expected_beats.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = index;
        cfg_data  = value;
        @(posedge clk);
        sb.set_reg(index, value);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    task automatic reconfigure(logic [CFG_DATA_W-1:0] timeout_val,
                               logic [CFG_DATA_W-1:0] period_val);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(CFG_TIMEOUT, timeout_val);
        write_reg(CFG_PERIOD, period_val);
    endtask

    initial
    begin
        int p;
        int n;
        int k;
        int pick;
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] grp;

        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_index            = '0;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = '0;
        req_ch.peer_address  = '0;
        req_ch.group_id      = '0;
        req_ch.position      = '0;
        req_ch.command_code  = '0;
        req_ch.command_param = '0;
        rsp_ch.ready         = 1'b0;

        addr_pool[0] = '0;
        addr_pool[1] = '1;
        for (k = 2; k < POOL_SIZE; k++)
            addr_pool[k] = $urandom;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed opening at the reset register values.
        send_item(REQ_GROUP, 32'h0, 8'h00, 8'h00, 8'h11, 8'h22);
        send_item(REQ_NONE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_ANNOUNCE, 32'h0000_0000, 8'h00, 8'h00, 8'h00, 8'h00);
        send_item(REQ_ANNOUNCE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_item(REQ_ANNOUNCE, 32'h0000_0000, 8'h01, 8'h80, 8'h00, 8'h00);
        send_item(REQ_GROUP, 32'h0, 8'hFF, 8'h00, 8'hFF, 8'h00);
        send_item(REQ_GROUP, 32'h0, 8'h01, 8'h00, 8'h00, 8'hFF);
        send_item(REQ_GROUP, 32'h0, 8'h55, 8'h00, 8'hA5, 8'h5A);
        for (k = 0; k < MAX_ENTRIES - 2; k++)
            send_item(REQ_ANNOUNCE, 32'h0A00_0001 + k, 8'h02, 8'(k), 8'h00, 8'h00);
        // The list is full now, so an unknown address is dropped.
        send_item(REQ_ANNOUNCE, 32'h7F00_0001, 8'h02, 8'h10, 8'h00, 8'h00);
        send_item(REQ_GROUP, 32'h0, 8'h02, 8'h00, 8'h3C, 8'hC3);
        send_item(REQ_TICK, 32'h0, 8'h00, 8'h00, 8'h00, 8'h00);

        for (p = 0; p < PHASE_COUNT; p++)
        begin
            reconfigure(8'(phase_timeout[p]), 8'(phase_period[p]));
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                    wait_for_results();
                pick = $urandom_range(99);
                if (pick < 45)
                    kind = REQ_ANNOUNCE;
                else if (pick < 72)
                    kind = REQ_TICK;
                else if (pick < 96)
                    kind = REQ_GROUP;
                else
                    kind = REQ_NONE;
                addr = ($urandom_range(99) < 75) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
                                                 : $urandom;
                grp = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom);
                send_item(kind, addr, grp, 8'($urandom), 8'($urandom), 8'($urandom));
            end
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        wait_for_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
